FILE: rtl/rgb_color_filter_macros.svh
// Assertion helpers for the filter top level.
`ifndef RGB_COLOR_FILTER_MACROS_SVH
`define RGB_COLOR_FILTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RCF_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("rgb_color_filter: same-cycle check failed");

// Implication with a delay.
`define RCF_ASSERT_LAT3(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##3 (expr)) \
    else $error("rgb_color_filter: latency check failed");

`endif

FILE: rtl/rcf_pkg.sv
package rcf_pkg;

  // Filter modes; the two unused codes pass the pixel through.
  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_GRAY   = 3'd1,
    MODE_SEPIA  = 3'd2,
    MODE_INVERT = 3'd3,
    MODE_WARM   = 3'd4,
    MODE_COOL   = 3'd5
  } mode_t;

  localparam int ChW   = 8;
  localparam int CoefW = 16;
  localparam int ProdW = ChW + CoefW;
  localparam int SumW  = ProdW + 2;

  localparam logic [ChW-1:0] ChMax = 8'd255;

  // Tint offsets.
  localparam logic [ChW-1:0] WarmRed   = 8'd30;
  localparam logic [ChW-1:0] WarmGreen = 8'd15;
  localparam logic [ChW-1:0] CoolBlue  = 8'd35;
  localparam logic [ChW-1:0] CoolGreen = 8'd10;

  // Q0.16 coefficient rows: gray, then the sepia rows for red, green, blue.
  localparam logic [CoefW-1:0] CoefTab [4][3] = '{
    '{16'd19595, 16'd38470, 16'd7471},
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  typedef struct packed {
    logic [ChW-1:0] r;
    logic [ChW-1:0] g;
    logic [ChW-1:0] b;
  } pix_t;

  // Control that travels with each pipeline stage.
  typedef struct packed {
    logic  valid;
    mode_t mode;
  } ctl_t;

  typedef logic [ProdW-1:0] prod_t;
  typedef prod_t [2:0] prod_row_t;
  typedef prod_row_t [2:0] prod_mat_t;

  // Add with saturation at full scale.
  function automatic logic [ChW-1:0] sat_add(logic [ChW-1:0] v, logic [ChW-1:0] k);
    logic [ChW:0] s;
    s = {1'b0, v} + {1'b0, k};
    return s[ChW] ? ChMax : s[ChW-1:0];
  endfunction

endpackage

FILE: rtl/rcf_mult.sv
// Stage one: nine coefficient products, rows chosen by the mode.
module rcf_mult import rcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  ctl_t      ctl_in,
  input  pix_t      pix_in,
  output ctl_t      ctl,
  output pix_t      pix,
  output prod_mat_t prod
);

  logic [1:0] row [3];
  logic [ChW-1:0] chan [3];
  prod_mat_t prod_next;

  assign chan[0] = pix_in.r;
  assign chan[1] = pix_in.g;
  assign chan[2] = pix_in.b;

  // Gray uses its single row for every channel; otherwise one sepia row per channel.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      row[c] = (ctl_in.mode == MODE_GRAY) ? 2'd0 : 2'(c + 1);
      for (int k = 0; k < 3; k++) begin
        prod_next[c][k] = ProdW'(CoefTab[row[c]][k]) * ProdW'(chan[k]);
      end
    end
  end

  // Stage registers; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (en) begin
      ctl.mode <= ctl_in.mode;
      pix      <= pix_in;
      prod     <= prod_next;
    end
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
  end

endmodule

FILE: rtl/rcf_sum.sv
// Stage two: row sums with clamp, plus the saturating tints.
module rcf_sum import rcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  ctl_t      ctl_in,
  input  pix_t      pix_in,
  input  prod_mat_t prod,
  output ctl_t      ctl,
  output pix_t      pix,
  output pix_t      mat_pix,
  output pix_t      warm_pix,
  output pix_t      cool_pix
);

  logic [ChW-1:0] mat_next [3];
  logic [SumW-1:0] acc [3];
  logic [SumW-17:0] whole [3];

  // Sum each row, drop the 16 fraction bits, clamp to full scale.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c]      = SumW'(prod[c][0]) + SumW'(prod[c][1]) + SumW'(prod[c][2]);
      whole[c]    = acc[c][SumW-1:16];
      mat_next[c] = (whole[c] > (SumW-16)'(ChMax)) ? ChMax : whole[c][ChW-1:0];
    end
  end

  // Stage registers; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (en) begin
      ctl.mode   <= ctl_in.mode;
      pix        <= pix_in;
      mat_pix.r  <= mat_next[0];
      mat_pix.g  <= mat_next[1];
      mat_pix.b  <= mat_next[2];
      warm_pix.r <= sat_add(pix_in.r, WarmRed);
      warm_pix.g <= sat_add(pix_in.g, WarmGreen);
      warm_pix.b <= pix_in.b;
      cool_pix.r <= pix_in.r;
      cool_pix.g <= sat_add(pix_in.g, CoolGreen);
      cool_pix.b <= sat_add(pix_in.b, CoolBlue);
    end
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
  end

endmodule

FILE: rtl/rcf_select.sv
// Stage three: pick the result for the mode and hold it for the consumer.
module rcf_select import rcf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  ctl_t ctl_in,
  input  pix_t pix_in,
  input  pix_t mat_pix,
  input  pix_t warm_pix,
  input  pix_t cool_pix,
  output ctl_t ctl,
  output pix_t pix
);

  pix_t pix_next;

  // Result mux; gray carries its one value in every channel of mat_pix.
  always_comb begin
    case (ctl_in.mode)
      MODE_GRAY, MODE_SEPIA: pix_next = mat_pix;
      MODE_INVERT:           pix_next = ~pix_in;
      MODE_WARM:             pix_next = warm_pix;
      MODE_COOL:             pix_next = cool_pix;
      default:               pix_next = pix_in;
    endcase
  end

  // Output register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (en) begin
      ctl.mode <= ctl_in.mode;
      pix      <= pix_next;
    end
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
  end

endmodule

FILE: rtl/rgb_color_filter.sv
// Channel   Handshake                 Payload
// cfg       cfg_valid / cfg_ready     filter_mode[2:0]
// in        in_valid / in_stall       red_in, green_in, blue_in [7:0]
// out       out_valid / out_stall     red_out, green_out, blue_out [7:0]
//
// One pixel is accepted per cycle while in_stall is low; a result passes the product, row-sum and select registers.
// The depth is set by the three stages: products, row sums, result select.
// Synchronous reset empties the pipeline and sets the mode to pass-through.
// Each stage advances when the stage after it is empty or moving, so bubbles
// close up under a stall and in_stall rises only when the first stage is held.
module rgb_color_filter import rcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] filter_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out
);

`include "rgb_color_filter_macros.svh"

  mode_t mode;
  ctl_t ctl_in, ctl1, ctl2, ctl3;
  pix_t pix_in, pix1, pix2, pix3;
  pix_t mat_pix, warm_pix, cool_pix;
  prod_mat_t prod;
  logic en1, en2, en3;
  logic gray_beat, empty_accept;

  // Mode register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (cfg_valid) begin
      mode <= mode_t'(filter_mode);
    end
  end

  // Stage enables, from the output back.
  assign en3      = !ctl3.valid || !out_stall;
  assign en2      = !ctl2.valid || en3;
  assign en1      = !ctl1.valid || en2;
  assign in_stall = !en1;

  assign ctl_in.valid = in_valid;
  assign ctl_in.mode  = mode;
  assign pix_in.r     = red_in;
  assign pix_in.g     = green_in;
  assign pix_in.b     = blue_in;

  rcf_mult u_mult (
    .clk    (clk),
    .rst    (rst),
    .en     (en1),
    .ctl_in (ctl_in),
    .pix_in (pix_in),
    .ctl    (ctl1),
    .pix    (pix1),
    .prod   (prod)
  );

  rcf_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .en       (en2),
    .ctl_in   (ctl1),
    .pix_in   (pix1),
    .prod     (prod),
    .ctl      (ctl2),
    .pix      (pix2),
    .mat_pix  (mat_pix),
    .warm_pix (warm_pix),
    .cool_pix (cool_pix)
  );

  rcf_select u_select (
    .clk      (clk),
    .rst      (rst),
    .en       (en3),
    .ctl_in   (ctl2),
    .pix_in   (pix2),
    .mat_pix  (mat_pix),
    .warm_pix (warm_pix),
    .cool_pix (cool_pix),
    .ctl      (ctl3),
    .pix      (pix3)
  );

  assign out_valid = ctl3.valid;
  assign red_out   = pix3.r;
  assign green_out = pix3.g;
  assign blue_out  = pix3.b;

  // Conditions named for the checks below.
  assign gray_beat    = out_valid && ctl3.mode == MODE_GRAY;
  assign empty_accept = in_valid && !in_stall && !(ctl1.valid || ctl2.valid || ctl3.valid);

  // Checks on the pipeline.
  `RCF_ASSERT_NOW(a_stall_only_when_full, in_stall, ctl1.valid && ctl2.valid && ctl3.valid)
  `RCF_ASSERT_NOW(a_gray_equal, gray_beat, red_out == green_out && green_out == blue_out)
  `RCF_ASSERT_LAT3(a_empty_latency, empty_accept, out_valid)

endmodule
